// ===== design/mfs_pkg.sv =====
// Shared types, sizes and helper functions for the multilevel feedback scheduler.
// Depends on nothing; used by mfs_ram users and multilevel_feedback_scheduler_core.
package mfs_pkg;

  localparam int MAX_JOBS  = 64;
  localparam int LEVELS    = 3;
  localparam int JOB_W     = 6;
  localparam int LVL_OUT_W = 2;
  localparam int ACT_W     = 3;

  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int JOB_AW   = SLOT_W;
  localparam int QS_DEPTH = LEVELS * MAX_JOBS;
  localparam int QS_AW    = $clog2(QS_DEPTH);
  localparam int JT_W     = LVL_W + 1;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_IDLE      = 3'd0,
    ACT_QUEUED    = 3'd1,
    ACT_FINISHED  = 3'd2,
    ACT_PREEMPTED = 3'd3,
    ACT_STARTED   = 3'd4,
    ACT_RESUMED   = 3'd5,
    ACT_REJECTED  = 3'd6
  } action_e;

  typedef struct packed {
    op_e              operation;
    logic [JOB_W-1:0] job_id;
    logic             job_ended;
  } sched_in_t;

  typedef struct packed {
    action_e              action;
    logic [JOB_W-1:0]     job_out;
    logic [LVL_OUT_W-1:0] level_out;
    logic                 busy_res;
  } sched_out_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             started;
  } jt_entry_t;

  function automatic logic [JOB_AW-1:0] job_index(input logic [JOB_W-1:0] id);
    return JOB_AW'(id % MAX_JOBS);
  endfunction

  // head + count wrapped; count is below MAX_JOBS whenever a push is made
  function automatic logic [SLOT_W-1:0] tail_slot(input logic [SLOT_W-1:0] head,
                                                   input logic [CNT_W-1:0]  cnt);
    logic [SLOT_W:0] s;
    s = (SLOT_W+1)'(head) + (SLOT_W+1)'(cnt);
    if (s >= (SLOT_W+1)'(MAX_JOBS)) begin
      s = s - (SLOT_W+1)'(MAX_JOBS);
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    return (slot == SLOT_W'(MAX_JOBS - 1)) ? '0 : slot + 1'b1;
  endfunction

  function automatic logic [QS_AW-1:0] qs_addr(input logic [LVL_W-1:0]  lvl,
                                               input logic [SLOT_W-1:0] slot);
    return QS_AW'(lvl * MAX_JOBS) + QS_AW'(slot);
  endfunction

endpackage

// ===== design/mfs_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/multilevel_feedback_scheduler_core.sv =====
// Top level of the multilevel feedback-queue scheduler: queue RAM, job table RAM, sequencer.
// Depends on mfs_pkg and mfs_ram.
//
//   channel  | ports                     | handshake
//   ---------+---------------------------+-----------------------------------
//   command  | start_i, busy_o, in_i     | word taken when start_i & !busy_o
//   result   | res_valid_o, res_o        | one-cycle strobe, no back-pressure
//
// Arrival, finish and idle ticks: result strobed on the next cycle.
// Preemption passes through S_PRE (job table read). Dispatch passes through S_DQ (queue RAM
// read), then S_DS (job table read of the popped id). busy_o is high in these states.
// A new word may be taken while the previous result is on the result ports.
// Reset clears queue heads, fill counts and the running job; RAM contents are not cleared.
module multilevel_feedback_scheduler_core
  import mfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  sched_in_t  in_i,
  output logic       res_valid_o,
  output sched_out_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_DQ   = 2'd2;
  localparam logic [1:0] S_DS   = 2'd3;

  localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q [LEVELS];
  logic [SLOT_W-1:0] head_d [LEVELS];
  logic [CNT_W-1:0]  cnt_q  [LEVELS];
  logic [CNT_W-1:0]  cnt_d  [LEVELS];
  logic              running_q, running_d;
  logic [JOB_W-1:0]  run_job_q, run_job_d;
  logic              res_valid_q, res_valid_d;
  sched_out_t        res_q, res_d;
  logic [LVL_W-1:0]  src_q, src_d;
  logic [JOB_W-1:0]  job_q, job_d;

  logic              qs_we;
  logic [QS_AW-1:0]  qs_addr_w;
  logic [JOB_W-1:0]  qs_wdata, qs_rdata;
  logic              jt_we;
  logic [JOB_AW-1:0] jt_addr;
  jt_entry_t         jt_wdata;
  logic [JT_W-1:0]   jt_rdata;
  jt_entry_t         jt_rd;

  logic              any_ne;
  logic [LVL_W-1:0]  hi_lvl;
  logic [LVL_W-1:0]  cur_lvl, nl;

  mfs_ram #(.WIDTH(JOB_W), .DEPTH(QS_DEPTH)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (qs_we),
    .addr_i (qs_addr_w),
    .wdata_i(qs_wdata),
    .rdata_o(qs_rdata)
  );

  mfs_ram #(.WIDTH(JT_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (jt_we),
    .addr_i (jt_addr),
    .wdata_i(jt_wdata),
    .rdata_o(jt_rdata)
  );

  assign jt_rd = jt_entry_t'(jt_rdata);

  always_comb begin
    any_ne = 1'b0;
    hi_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_q[l] != '0) begin
        any_ne = 1'b1;
        hi_lvl = LVL_W'(l);
      end
    end
  end

  always_comb begin
    cur_lvl = jt_rd.level;
    nl      = (cur_lvl != '0) ? cur_lvl - 1'b1 : '0;
    if (nl > TOP) begin
      nl = TOP;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    running_d   = running_q;
    run_job_d   = run_job_q;
    src_d       = src_q;
    job_d       = job_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    qs_we       = 1'b0;
    qs_addr_w   = '0;
    qs_wdata    = '0;
    jt_we       = 1'b0;
    jt_addr     = '0;
    jt_wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d.action    = ACT_IDLE;
          res_d.job_out   = '0;
          res_d.level_out = '0;
          res_d.busy_res  = running_q;
          res_valid_d     = 1'b1;
          if (in_i.operation == OP_ARRIVE) begin
            res_d.job_out   = in_i.job_id;
            res_d.level_out = LVL_OUT_W'(TOP);
            if (cnt_q[TOP] < CNT_W'(MAX_JOBS)) begin
              qs_we            = 1'b1;
              qs_addr_w        = qs_addr(TOP, tail_slot(head_q[TOP], cnt_q[TOP]));
              qs_wdata         = in_i.job_id;
              cnt_d[TOP]       = cnt_q[TOP] + 1'b1;
              jt_we            = 1'b1;
              jt_addr          = job_index(in_i.job_id);
              jt_wdata.level   = TOP;
              jt_wdata.started = 1'b0;
              res_d.action     = ACT_QUEUED;
            end else begin
              res_d.action = ACT_REJECTED;
            end
          end else if (running_q) begin
            if (in_i.job_ended) begin
              running_d      = 1'b0;
              res_d.action   = ACT_FINISHED;
              res_d.job_out  = run_job_q;
              res_d.busy_res = 1'b0;
            end else if (any_ne) begin
              jt_addr     = job_index(run_job_q);
              res_valid_d = 1'b0;
              state_d     = S_PRE;
            end
          end else if (any_ne) begin
            qs_addr_w   = qs_addr(hi_lvl, head_q[hi_lvl]);
            src_d       = hi_lvl;
            res_valid_d = 1'b0;
            state_d     = S_DQ;
          end
        end
      end
      S_PRE: begin
        res_d.job_out   = run_job_q;
        res_d.level_out = LVL_OUT_W'(nl);
        if (cnt_q[nl] < CNT_W'(MAX_JOBS)) begin
          qs_we            = 1'b1;
          qs_addr_w        = qs_addr(nl, tail_slot(head_q[nl], cnt_q[nl]));
          qs_wdata         = run_job_q;
          cnt_d[nl]        = cnt_q[nl] + 1'b1;
          jt_we            = 1'b1;
          jt_addr          = job_index(run_job_q);
          jt_wdata.level   = nl;
          jt_wdata.started = jt_rd.started;
          running_d        = 1'b0;
          res_d.action     = ACT_PREEMPTED;
          res_d.busy_res   = 1'b0;
        end else begin
          jt_addr        = job_index(run_job_q);
          res_d.action   = ACT_REJECTED;
          res_d.busy_res = 1'b1;
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DQ: begin
        job_d         = qs_rdata;
        head_d[src_q] = next_slot(head_q[src_q]);
        cnt_d[src_q]  = cnt_q[src_q] - 1'b1;
        jt_addr       = job_index(qs_rdata);
        state_d       = S_DS;
      end
      S_DS: begin
        jt_addr          = job_index(job_q);
        jt_we            = 1'b1;
        jt_wdata.level   = jt_rd.level;
        jt_wdata.started = 1'b1;
        running_d        = 1'b1;
        run_job_d        = job_q;
        res_d.action     = jt_rd.started ? ACT_RESUMED : ACT_STARTED;
        res_d.job_out    = job_q;
        res_d.level_out  = LVL_OUT_W'(src_q);
        res_d.busy_res   = 1'b1;
        res_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      run_job_q   <= '0;
      res_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      run_job_q   <= run_job_d;
      res_valid_q <= res_valid_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    src_q <= src_d;
    job_q <= job_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a taken word either strobes a result next cycle or keeps the block busy
  a_word_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (res_valid_o || busy_o))
    else $error("accepted word produced neither a result nor a busy cycle");

  a_dq_to_ds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DQ) |=> (state_q == S_DS))
    else $error("queue read not followed by job table read");

  a_dispatch_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DS) |=> (running_q && res_valid_o && res_o.busy_res))
    else $error("dispatch did not leave a job running");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.action == ACT_STARTED || res_o.action == ACT_RESUMED))
      |-> (running_q && run_job_q == res_o.job_out))
    else $error("dispatch result disagrees with running job");

  for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
    a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] <= CNT_W'(MAX_JOBS))
      else $error("queue fill count beyond capacity");
  end

endmodule

// ===== tb/multilevel_feedback_scheduler_core_tb.sv =====
// Self-checking testbench for multilevel_feedback_scheduler_core: a scheduler mirror predicts
// every result word, a driver/monitor pair exercises the command and result channels.
// Depends on mfs_pkg and the scheduler RTL.
module multilevel_feedback_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  localparam int TOP_LVL   = LEVELS - 1;
  localparam int STALL_CAP = 2000;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  sched_in_t  in_i    = '0;
  logic       busy_o;
  logic       res_valid_o;
  sched_out_t res_o;

  multilevel_feedback_scheduler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // scheduler mirror
  logic [JOB_W-1:0] lvl_store [LEVELS][MAX_JOBS];
  int               lvl_head  [LEVELS] = '{default: 0};
  int               lvl_fill  [LEVELS] = '{default: 0};
  int               job_lvl   [MAX_JOBS];
  bit               job_seen  [MAX_JOBS];
  logic [JOB_W-1:0] cur_job   = '0;
  bit               cur_valid = 1'b0;

  sched_in_t  cmd_words[$];
  sched_out_t sched_decisions[$];
  int         gap_pct      = 0;
  int         mismatches   = 0;
  int         quiet_cycles = 0;

  function automatic bit enqueue_job(input int lvl, input logic [JOB_W-1:0] id);
    if (lvl_fill[lvl] >= MAX_JOBS) begin
      return 1'b0;
    end
    lvl_store[lvl][(lvl_head[lvl] + lvl_fill[lvl]) % MAX_JOBS] = id;
    lvl_fill[lvl]++;
    return 1'b1;
  endfunction

  function automatic sched_out_t schedule_step(input sched_in_t w);
    sched_out_t       r;
    int               src;
    int               nl;
    logic [JOB_W-1:0] j;
    r        = '0;
    r.action = ACT_IDLE;
    src      = -1;
    for (int l = TOP_LVL; l >= 0; l--) begin
      if (src < 0 && lvl_fill[l] != 0) begin
        src = l;
      end
    end
    if (w.operation == OP_ARRIVE) begin
      r.job_out   = w.job_id;
      r.level_out = LVL_OUT_W'(TOP_LVL);
      if (enqueue_job(TOP_LVL, w.job_id)) begin
        job_lvl[w.job_id % MAX_JOBS]  = TOP_LVL;
        job_seen[w.job_id % MAX_JOBS] = 1'b0;
        r.action = ACT_QUEUED;
      end else begin
        r.action = ACT_REJECTED;
      end
    end else if (cur_valid) begin
      if (w.job_ended) begin
        cur_valid = 1'b0;
        r.action  = ACT_FINISHED;
        r.job_out = cur_job;
      end else if (src >= 0) begin
        nl          = (job_lvl[cur_job % MAX_JOBS] > 0) ? job_lvl[cur_job % MAX_JOBS] - 1 : 0;
        r.job_out   = cur_job;
        r.level_out = LVL_OUT_W'(nl);
        if (enqueue_job(nl, cur_job)) begin
          job_lvl[cur_job % MAX_JOBS] = nl;
          cur_valid = 1'b0;
          r.action  = ACT_PREEMPTED;
        end else begin
          r.action = ACT_REJECTED;
        end
      end
    end else if (src >= 0) begin
      j             = lvl_store[src][lvl_head[src]];
      lvl_head[src] = (lvl_head[src] + 1) % MAX_JOBS;
      lvl_fill[src]--;
      if (job_seen[j % MAX_JOBS]) begin
        r.action = ACT_RESUMED;
      end else begin
        r.action = ACT_STARTED;
      end
      job_seen[j % MAX_JOBS] = 1'b1;
      cur_job     = j;
      cur_valid   = 1'b1;
      r.job_out   = j;
      r.level_out = LVL_OUT_W'(src);
    end
    r.busy_res = cur_valid;
    return r;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      in_i    <= '0;
    end else begin
      if (start_i && !busy_o) begin
        sched_decisions.push_back(schedule_step(in_i));
      end
      if (!start_i || !busy_o) begin
        if (cmd_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start_i <= 1'b1;
          in_i    <= cmd_words.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    sched_out_t exp_w;
    if (rst_ni && res_valid_o) begin
      if (sched_decisions.size() == 0) begin
        $error("unexpected result word: action %0d job %0d", res_o.action, res_o.job_out);
        mismatches++;
      end else begin
        exp_w = sched_decisions.pop_front();
        if (res_o.action !== exp_w.action) begin
          $error("action: expected %0d, got %0d", exp_w.action, res_o.action);
          mismatches++;
        end
        if (res_o.job_out !== exp_w.job_out) begin
          $error("job_out: expected %0d, got %0d", exp_w.job_out, res_o.job_out);
          mismatches++;
        end
        if (res_o.level_out !== exp_w.level_out) begin
          $error("level_out: expected %0d, got %0d", exp_w.level_out, res_o.level_out);
          mismatches++;
        end
        if (res_o.busy_res !== exp_w.busy_res) begin
          $error("busy_res: expected %0d, got %0d", exp_w.busy_res, res_o.busy_res);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_CAP) begin
        $display("multilevel_feedback_scheduler_core_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic add_word(input op_e op, input logic [JOB_W-1:0] id, input logic ended);
    sched_in_t w;
    w.operation = op;
    w.job_id    = id;
    w.job_ended = ended;
    cmd_words.push_back(w);
  endtask

  task automatic add_ticks(input int n, input logic ended);
    for (int i = 0; i < n; i++) begin
      add_word(OP_TICK, JOB_W'($urandom), ended);
    end
  endtask

  task automatic settle();
    while (cmd_words.size() != 0 || start_i || sched_decisions.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int arrive_pct [4];
    int gap_sched  [4];
    int backlog;
    arrive_pct = '{50, 35, 60, 45};
    gap_sched  = '{0, 50, 0, 31};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ticks, repeated ids, demotion down to the floor, keep-running tick
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd63, 1'b1);
    add_word(OP_ARRIVE, 6'd0,  1'b1);
    add_word(OP_ARRIVE, 6'd63, 1'b0);
    add_word(OP_ARRIVE, 6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd63, 1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b1);
    add_word(OP_TICK,   6'd63, 1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b1);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd63, 1'b0);
    add_word(OP_ARRIVE, 6'd42, 1'b1);
    add_word(OP_ARRIVE, 6'd21, 1'b0);
    add_word(OP_TICK,   6'd21, 1'b0);
    add_word(OP_TICK,   6'd0,  1'b0);
    add_word(OP_TICK,   6'd0,  1'b1);
    add_word(OP_TICK,   6'd42, 1'b0);
    add_word(OP_TICK,   6'd0,  1'b1);
    add_word(OP_TICK,   6'd0,  1'b1);
    settle();

    // mixed traffic, one gap setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_sched[ph];
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99) < arrive_pct[ph]) begin
          add_word(OP_ARRIVE, JOB_W'($urandom), 1'($urandom));
        end else begin
          add_word(OP_TICK, JOB_W'($urandom), $urandom_range(99) < 35);
        end
      end
      settle();
    end

    // empty every queue so the overflow sequences start from a known fill
    gap_pct = 31;
    backlog = 2 * (lvl_fill[0] + lvl_fill[1] + lvl_fill[2]) + int'(cur_valid);
    add_ticks(backlog, 1'b1);
    settle();

    // top queue overflow, then demoted jobs fill level 1 and the last running job is refused
    gap_pct = 50;
    for (int i = 0; i <= MAX_JOBS; i++) begin
      add_word(OP_ARRIVE, JOB_W'($urandom), 1'($urandom));
    end
    add_ticks(2 * MAX_JOBS, 1'b0);
    add_word(OP_ARRIVE, JOB_W'($urandom), 1'b0);
    add_ticks(3, 1'b0);
    add_ticks(1, 1'b1);
    settle();

    // level 1 drains into level 0 until full, then a demotion into it is refused
    gap_pct = 0;
    add_ticks(2 * MAX_JOBS, 1'b0);
    add_word(OP_ARRIVE, JOB_W'($urandom), 1'b1);
    add_ticks(4, 1'b0);
    settle();

    gap_pct = 31;
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(99) < 30) begin
        add_word(OP_ARRIVE, JOB_W'($urandom), 1'($urandom));
      end else begin
        add_word(OP_TICK, JOB_W'($urandom), $urandom_range(99) < 50);
      end
    end
    settle();

    repeat (8) @(posedge clk_i);
    if (sched_decisions.size() != 0) begin
      $error("%0d result words never arrived", sched_decisions.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("multilevel_feedback_scheduler_core_tb: done, clean");
    end else begin
      $display("multilevel_feedback_scheduler_core_tb: done, errors");
    end
    $finish;
  end

endmodule
